// ===== rtl/sorted_key_list_top_defines.svh =====
// Assertion macros for the sorted key list.
// Each expects clk and rst_n in the scope where it is used.
`ifndef SORTED_KEY_LIST_TOP_DEFINES_SVH
`define SORTED_KEY_LIST_TOP_DEFINES_SVH

// Same-cycle implication.
`define SLC_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define SLC_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/slc_pkg.sv =====
`timescale 1ns / 1ps

package slc_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int PIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int MATCH_W  = 7;
    localparam int ENTRY_W  = 7;

    localparam logic [KEY_W-1:0] KEY_INVALID = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT        = 3'd0,
        CMD_INSERT_UNIQUE = 3'd1,
        CMD_INDEX_OF      = 3'd2,
        CMD_COUNT         = 3'd3,
        CMD_REMOVE_AT     = 3'd4,
        CMD_GET_AT        = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_INVALID  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_DEL
    } cell_op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t                op;
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        idx;
    } cell_ctrl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    valid;
        logic                    lt;
        logic                    le;
    } cell_state_t;

    // boundary flags of the lower and upper bound
    typedef struct packed {
        logic lt_hit;
        logic le_hit;
    } cell_hit_t;

endpackage

// ===== rtl/slc_cell.sv =====
`timescale 1ns / 1ps

module slc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [slc_pkg::IDX_W-1:0]     cell_idx,
    input  slc_pkg::cell_ctrl_t           ctrl,
    input  slc_pkg::cell_state_t          left_st,
    input  slc_pkg::cell_state_t          right_st,
    output slc_pkg::cell_state_t          st,
    output slc_pkg::cell_hit_t            hit,
    output logic [slc_pkg::KEY_W-1:0]     rd_key
);

    logic signed [slc_pkg::KEY_W-1:0] key_reg, key_next;
    logic valid_reg, valid_next;
    logic lt_reg, lt_next;
    logic le_reg, le_next;

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            le_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            le_reg    <= le_next;
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        lt_next    = lt_reg;
        le_next    = le_reg;
        case (ctrl.op)
            slc_pkg::CELL_CMP:
            begin
                lt_next = valid_reg && ($signed(key_reg) <  $signed(ctrl.key));
                le_next = valid_reg && ($signed(key_reg) <= $signed(ctrl.key));
            end
            slc_pkg::CELL_INS:
            begin
                // cells below the insertion point keep their key
                if (!lt_reg)
                begin
                    if (left_st.lt)
                    begin
                        key_next   = ctrl.key;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        key_next   = left_st.key;
                        valid_next = left_st.valid;
                    end
                end
            end
            slc_pkg::CELL_DEL:
            begin
                if (cell_idx >= ctrl.idx)
                begin
                    key_next   = right_st.key;
                    valid_next = right_st.valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign st.key    = key_reg;
    assign st.valid  = valid_reg;
    assign st.lt     = lt_reg;
    assign st.le     = le_reg;
    assign hit.lt_hit = !lt_reg && left_st.lt;
    assign hit.le_hit = !le_reg && left_st.le;
    assign rd_key    = (cell_idx == ctrl.idx) ? key_reg : '0;

endmodule

// ===== rtl/slc_enc.sv =====
`timescale 1ns / 1ps

module slc_enc (
    input  logic [slc_pkg::CAPACITY:0]   hit_vec,
    output logic [slc_pkg::CNT_W-1:0]    pos
);

    // exactly one bit is set: the bound lies where a prefix of flags ends
    always_comb
    begin
        pos = '0;
        for (int i = 0; i <= slc_pkg::CAPACITY; i++)
        begin
            if (hit_vec[i])
            begin
                pos = pos | slc_pkg::CNT_W'(i);
            end
        end
    end

endmodule

// ===== rtl/sorted_key_list_top.sv =====
`timescale 1ns / 1ps
// Sorted key list: a chain of compare-and-shift cells, one per stored key.
// The request is registered when taken, the cells compare in S_CMP, and the result word is registered in S_UPD.
// One request at a time (s_tready is high only in idle); steps: take, cell compare, cell shift/answer.
// A result word still waiting on m_tready holds the update cycle, and with it the input.
// Reset (rst_n low, async): list empty, no result pending, ready to accept.

`include "sorted_key_list_top_defines.svh"

module sorted_key_list_top (
    input  logic        clk,
    input  logic        rst_n,
    // request word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // key[31:0], index[37:32], zero pad
    input  logic [2:0]  s_tuser,  // cmd[2:0]
    // result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // key_out[31:0], position[37:32],
                                  // match_count[44:38], entry_count[51:45], zero pad
    output logic [2:0]  m_tuser   // status[2:0]
);

    localparam int N = slc_pkg::CAPACITY;

    // ---------------- control ----------------
    slc_pkg::state_t state_reg, state_next;

    logic [slc_pkg::CMD_W-1:0]    cmd_reg;
    logic [slc_pkg::KEY_W-1:0]    key_reg;
    logic [slc_pkg::PIDX_W-1:0]   idx_reg;
    logic [slc_pkg::CNT_W-1:0]    held_count_reg, held_count_next;

    logic                         out_valid_reg, out_valid_next;
    logic [slc_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [slc_pkg::KEY_W-1:0]    key_out_reg, key_out_next;
    logic [slc_pkg::POS_W-1:0]    position_reg, position_next;
    logic [slc_pkg::MATCH_W-1:0]  match_reg, match_next;
    logic [slc_pkg::ENTRY_W-1:0]  entry_reg, entry_next;

    logic in_fire, out_fire, out_free, finish;
    logic do_ins, do_del;

    slc_pkg::cell_ctrl_t ctrl;

    // ---------------- cell chain ----------------
    slc_pkg::cell_state_t cst [N];
    slc_pkg::cell_hit_t   chit [N];
    logic [slc_pkg::KEY_W-1:0] crd [N];
    slc_pkg::cell_state_t left_edge_st, right_edge_st;

    // left of cell 0 counts as smaller than any key; right of the last is empty
    assign left_edge_st  = '{key: '0, valid: 1'b1, lt: 1'b1, le: 1'b1};
    assign right_edge_st = '{key: '0, valid: 1'b0, lt: 1'b0, le: 1'b0};

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        slc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (slc_pkg::IDX_W'(g)),
            .ctrl     (ctrl),
            .left_st  ((g == 0) ? left_edge_st : cst[(g == 0) ? 0 : g - 1]),
            .right_st ((g == N - 1) ? right_edge_st : cst[(g == N - 1) ? g : g + 1]),
            .st       (cst[g]),
            .hit      (chit[g]),
            .rd_key   (crd[g])
        );
    end

    // bound flags, with one virtual slot past the last cell
    logic [N:0] lt_vec, le_vec;
    logic [N-1:0] valid_vec;
    logic [slc_pkg::CNT_W-1:0] lb, ub, span;
    logic [slc_pkg::KEY_W-1:0] rd_key;

    always_comb
    begin
        rd_key = '0;
        for (int i = 0; i < N; i++)
        begin
            lt_vec[i]    = chit[i].lt_hit;
            le_vec[i]    = chit[i].le_hit;
            valid_vec[i] = cst[i].valid;
            rd_key       = rd_key | crd[i];
        end
        lt_vec[N] = cst[N-1].lt;
        le_vec[N] = cst[N-1].le;
    end

    slc_enc u_enc_lb (.hit_vec(lt_vec), .pos(lb));
    slc_enc u_enc_ub (.hit_vec(le_vec), .pos(ub));

    // equal keys form one run from the lower to the upper bound
    assign span = ub - lb;

    // ---------------- handshake ----------------
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= slc_pkg::S_IDLE;
            held_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= s_tuser;
            key_reg <= s_tdata[31:0];
            idx_reg <= s_tdata[37:32];
        end
        status_reg   <= status_next;
        key_out_reg  <= key_out_next;
        position_reg <= position_next;
        match_reg    <= match_next;
        entry_reg    <= entry_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slc_pkg::S_IDLE: if (s_tvalid) state_next = slc_pkg::S_CMP;
            slc_pkg::S_CMP:  state_next = slc_pkg::S_UPD;
            slc_pkg::S_UPD:  if (out_free) state_next = slc_pkg::S_IDLE;
            default:         state_next = slc_pkg::S_IDLE;
        endcase
    end

    // state outputs; the cells see the held key and index throughout
    always_comb
    begin
        s_tready = 1'b0;
        finish   = 1'b0;
        ctrl.op  = slc_pkg::CELL_HOLD;
        ctrl.key = key_reg;
        ctrl.idx = slc_pkg::IDX_W'(idx_reg);
        unique case (state_reg)
            slc_pkg::S_IDLE: s_tready = 1'b1;
            slc_pkg::S_CMP:  ctrl.op  = slc_pkg::CELL_CMP;
            slc_pkg::S_UPD:
            begin
                finish = out_free;
                if (out_free && do_ins)
                begin
                    ctrl.op = slc_pkg::CELL_INS;
                end
                else if (out_free && do_del)
                begin
                    ctrl.op = slc_pkg::CELL_DEL;
                end
            end
            default:
            begin
            end
        endcase
    end

    // answer for the held request
    logic [slc_pkg::STATUS_W-1:0] res_status;
    logic [slc_pkg::KEY_W-1:0]    res_key;
    logic [slc_pkg::POS_W-1:0]    res_pos;
    logic [slc_pkg::MATCH_W-1:0]  res_match;
    logic                         in_range;

    assign in_range = slc_pkg::CNT_W'(idx_reg) < held_count_reg;

    always_comb
    begin
        res_status = slc_pkg::ST_OK;
        res_key    = '0;
        res_pos    = '0;
        res_match  = '0;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        case (cmd_reg)
            slc_pkg::CMD_INSERT, slc_pkg::CMD_INSERT_UNIQUE:
            begin
                if (key_reg == slc_pkg::KEY_INVALID)
                begin
                    res_status = slc_pkg::ST_INVALID;
                end
                else if (cmd_reg == slc_pkg::CMD_INSERT_UNIQUE && ub != lb)
                begin
                    res_status = slc_pkg::ST_DUP;
                end
                else if (held_count_reg == slc_pkg::CNT_W'(N))
                begin
                    res_status = slc_pkg::ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            slc_pkg::CMD_INDEX_OF:
            begin
                if (ub != lb)
                begin
                    res_pos = slc_pkg::POS_W'(lb);
                end
                else
                begin
                    res_status = slc_pkg::ST_NOTFOUND;
                end
            end
            slc_pkg::CMD_COUNT:
            begin
                res_match = slc_pkg::MATCH_W'(span);
            end
            slc_pkg::CMD_REMOVE_AT, slc_pkg::CMD_GET_AT:
            begin
                if (!in_range)
                begin
                    res_status = slc_pkg::ST_NOTFOUND;
                    res_key    = slc_pkg::KEY_INVALID;
                end
                else
                begin
                    res_key = rd_key;
                    do_del  = (cmd_reg == slc_pkg::CMD_REMOVE_AT);
                end
            end
            default:
            begin
                res_status = slc_pkg::ST_NOTFOUND;
            end
        endcase
    end

    // count and result register
    always_comb
    begin
        held_count_next = held_count_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        key_out_next    = key_out_reg;
        position_next   = position_reg;
        match_next      = match_reg;
        entry_next      = entry_reg;
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            if (do_ins)
            begin
                held_count_next = held_count_reg + 1'b1;
            end
            else if (do_del)
            begin
                held_count_next = held_count_reg - 1'b1;
            end
            out_valid_next = 1'b1;
            status_next    = res_status;
            key_out_next   = res_key;
            position_next  = res_pos;
            match_next     = res_match;
            entry_next     = slc_pkg::ENTRY_W'(held_count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0, entry_reg, match_reg, position_reg, key_out_reg};

    // ---------------- checks ----------------
    `SLC_ASSERT_IMP(a_count_max, 1'b1, held_count_reg <= slc_pkg::CNT_W'(N),
        "entry count beyond capacity")
    `SLC_ASSERT_IMP(a_valid_count, 1'b1,
        $countones(valid_vec) == 32'(held_count_reg),
        "cell valid bits disagree with entry count")
    `SLC_ASSERT_NEXT(a_count_stable, state_reg != slc_pkg::S_UPD, $stable(held_count_reg),
        "entry count changed outside update")
    `SLC_ASSERT_NEXT(a_take_to_cmp, in_fire, state_reg == slc_pkg::S_CMP,
        "accepted word did not start compare")

endmodule
